>>> sv/mftt_pkg.sv
// Shared types and constants for the motor feedback turn tracker.
// No dependencies; every other file of the block refers to it by scoped names.
package mftt_pkg;

  // Field widths.
  localparam int EncW   = 16;
  localparam int SpanW  = 17;
  localparam int RateW  = 17;
  localparam int TurnW  = 16;
  localparam int TotalW = 33;
  localparam int FrameW = 64;
  localparam int CountW = 16;
  localparam int CfgIdxW = 1;

  // Operation codes.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_ZERO  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SPAN  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TRACK = 1'b1;

  // Reset value of the span register: one full 16-bit encoder turn.
  localparam logic [SpanW-1:0] SPAN_RESET = 17'h10000;

  // Unwrapped turn count and rate for one feedback item.
  typedef struct packed {
    logic [TurnW-1:0]        turns;
    logic signed [RateW-1:0] rate;
  } unwrap_t;

endpackage

>>> sv/mftt_if.sv
// Handshake interfaces of the motor feedback turn tracker: feedback input,
// result output and configuration write channel. Depends on mftt_pkg.

interface mftt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [mftt_pkg::FrameW-1:0]   frame_data;

  modport source (output valid, output operation, output frame_data, input ready);
  modport sink   (input valid, input operation, input frame_data, output ready);
endinterface

interface mftt_out_if;
  logic                           valid;
  logic                           ready;
  logic [mftt_pkg::EncW-1:0]      encoder_value;
  logic signed [mftt_pkg::RateW-1:0]   encoder_rate;
  logic signed [mftt_pkg::TurnW-1:0]   turn_count;
  logic signed [mftt_pkg::TotalW-1:0]  total_position;
  logic signed [15:0]             speed_value;
  logic signed [15:0]             power_value;
  logic signed [7:0]              temperature_value;
  logic [mftt_pkg::CountW-1:0]    frame_count;

  modport source (output valid, output encoder_value, output encoder_rate,
                  output turn_count, output total_position, output speed_value,
                  output power_value, output temperature_value, output frame_count,
                  input ready);
  modport sink   (input valid, input encoder_value, input encoder_rate,
                  input turn_count, input total_position, input speed_value,
                  input power_value, input temperature_value, input frame_count,
                  output ready);
endinterface

interface mftt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mftt_pkg::CfgIdxW-1:0]   index;
  logic [mftt_pkg::SpanW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mftt_unwrap.sv
// Encoder unwrap: compares the new reading with the previous one against half
// the span and yields the new turn count and rate. Depends on mftt_pkg.
module mftt_unwrap (
  input  logic [mftt_pkg::EncW-1:0]  enc_new,
  input  logic [mftt_pkg::EncW-1:0]  enc_old,
  input  logic [mftt_pkg::SpanW-1:0] span,
  input  logic [mftt_pkg::TurnW-1:0] turns,
  output mftt_pkg::unwrap_t          res
);

  logic signed [18:0] diff;
  logic signed [18:0] half;
  logic signed [18:0] span_s;
  logic signed [18:0] rate_wide;

  // Signed difference and the span terms, wide enough for every span value.
  assign diff   = $signed({3'b000, enc_new}) - $signed({3'b000, enc_old});
  assign half   = $signed({3'b000, span[mftt_pkg::SpanW-1:1]});
  assign span_s = $signed({2'b00, span});

  // A jump of more than half a turn crosses the index mark.
  always_comb begin
    res.turns = turns;
    rate_wide = diff;
    if (diff > half) begin
      res.turns = turns - 16'd1;
      rate_wide = diff - span_s;
    end else if (diff < -half) begin
      res.turns = turns + 16'd1;
      rate_wide = diff + span_s;
    end
    res.rate = rate_wide[mftt_pkg::RateW-1:0];
  end

endmodule

>>> sv/motor_feedback_turn_tracker_top.sv
// Motor feedback turn tracker: input register, state update stage, result register.
// Throughput: one item per cycle unless a stalled result output holds the pipeline;
// the state update of one item is combinational unwrap logic, and the
// turns-times-span product is formed in the next stage.
// Reset (rst, synchronous): all pipeline stages empty, state zero, span 65536,
// tracking disabled. Depends on mftt_pkg, mftt_if and mftt_unwrap.
module motor_feedback_turn_tracker_top (
  input  logic          clk,
  input  logic          rst,
  mftt_in_if.sink       feedback,
  mftt_out_if.source    result,
  mftt_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [mftt_pkg::SpanW-1:0] span;
  logic                       track;

  // Input register.
  logic                        valid_a;
  logic                        op_a;
  logic [mftt_pkg::FrameW-1:0] data_a;

  // Update stage: what the result stage must do with the total.
  logic valid_b;
  logic recompute_b;
  logic zero_b;

  // Tracked state.
  logic [mftt_pkg::EncW-1:0]   current_encoder;
  logic [mftt_pkg::EncW-1:0]   zero_offset;
  logic [mftt_pkg::TurnW-1:0]  turns;
  logic [mftt_pkg::RateW-1:0]  rate_reg;
  logic [15:0]                 speed_reg;
  logic [15:0]                 power_reg;
  logic [7:0]                  temperature_reg;
  logic [mftt_pkg::CountW-1:0] frames_seen;

  // Result register.
  logic out_valid;

  logic adv_b;
  logic adv_c;
  logic b_free;
  logic a_free;
  logic [mftt_pkg::EncW-1:0] enc_in;
  mftt_pkg::unwrap_t         unwrap;
  logic signed [33:0]        product;
  logic [mftt_pkg::TotalW-1:0] total_next;

  // Pipeline flow control.
  assign adv_c  = valid_b && (!out_valid || result.ready);
  assign b_free = !valid_b || adv_c;
  assign adv_b  = valid_a && b_free;
  assign a_free = !valid_a || adv_b;
  assign feedback.ready = a_free;
  assign cfg.ready      = 1'b1;
  assign result.valid   = out_valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      span  <= mftt_pkg::SPAN_RESET;
      track <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mftt_pkg::CFG_SPAN:  span  <= cfg.data;
        mftt_pkg::CFG_TRACK: track <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (a_free) begin
      valid_a <= feedback.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && feedback.valid) begin
      op_a   <= feedback.operation;
      data_a <= feedback.frame_data;
    end
  end

  assign enc_in = data_a[63:48];

  mftt_unwrap u_unwrap (
    .enc_new (enc_in),
    .enc_old (current_encoder),
    .span    (span),
    .turns   (turns),
    .res     (unwrap)
  );

  // State update, one item per cycle while the update stage is free to advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_encoder <= '0;
      zero_offset     <= '0;
      turns           <= '0;
      rate_reg        <= '0;
      speed_reg       <= '0;
      power_reg       <= '0;
      temperature_reg <= '0;
      frames_seen     <= '0;
      valid_b         <= 1'b0;
      recompute_b     <= 1'b0;
      zero_b          <= 1'b0;
    end else begin
      if (b_free) begin
        valid_b <= valid_a;
      end
      if (adv_b) begin
        recompute_b <= 1'b0;
        zero_b      <= 1'b0;
        if (op_a == mftt_pkg::OP_ZERO) begin
          zero_offset <= current_encoder;
          turns       <= '0;
          zero_b      <= 1'b1;
        end else begin
          frames_seen     <= frames_seen + 16'd1;
          current_encoder <= enc_in;
          if (!track) begin
            zero_offset <= enc_in;
          end else begin
            turns           <= unwrap.turns;
            rate_reg        <= unwrap.rate;
            speed_reg       <= data_a[47:32];
            power_reg       <= data_a[31:16];
            temperature_reg <= data_a[15:8];
            recompute_b     <= 1'b1;
          end
        end
      end
    end
  end

  // Total position from the state left by the item in the update stage.
  assign product    = $signed(turns) * $signed({1'b0, span});
  assign total_next = product[mftt_pkg::TotalW-1:0]
                    + {17'd0, current_encoder} - {17'd0, zero_offset};

  // Result register; its total field doubles as the held total.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid             <= 1'b0;
      result.total_position <= '0;
    end else begin
      if (!out_valid || result.ready) begin
        out_valid <= valid_b;
      end
      if (adv_c) begin
        if (zero_b) begin
          result.total_position <= '0;
        end else if (recompute_b) begin
          result.total_position <= $signed(total_next);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      result.encoder_value     <= current_encoder;
      result.encoder_rate      <= $signed(rate_reg);
      result.turn_count        <= $signed(turns);
      result.speed_value       <= $signed(speed_reg);
      result.power_value       <= $signed(power_reg);
      result.temperature_value <= $signed(temperature_reg);
      result.frame_count       <= frames_seen;
    end
  end

endmodule
